/* rtl/plid_pkg.sv */
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types and constants for the positional list block.
// ----------------------------------------------------------------------------
package plid_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [2:0] OP_PREPEND = 3'd0;
	localparam logic [2:0] OP_APPEND  = 3'd1;
	localparam logic [2:0] OP_INSERT  = 3'd2;
	localparam logic [2:0] OP_DELETE  = 3'd3;
	localparam logic [2:0] OP_DUMP    = 3'd4;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NOENT = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic             apply;      // input transfer: perform the edit
		logic             emit_edit;  // load single edit result
		logic             emit_dump;  // load one dump result
		logic [IDX_W-1:0] dump_idx;
		logic             dump_last;
	} plid_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             empty;
	} plid_sts_t;

endpackage

/* rtl/positional_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of signed 32-bit values with positional insert and delete.
// ----------------------------------------------------------------------------
// Edit: result registered, valid in the cycle after acceptance; one edit per
// cycle while in_stall is low. Dump of N entries: one result per cycle from
// the entry mux while output is free; next transfer waits for the last one.
// Output register holds a result while stalled; the next edit waits while it
// is full and stalled, or during a dump. Reset clears the count and control; cells are not reset.
module positional_list_insert_delete import plid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic [7:0]         position,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] item_value,
	output logic [1:0]         status,
	output logic [6:0]         count,
	output logic               last
);

	plid_cmd_t cmd;
	plid_sts_t sts;

	plid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	plid_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.position   (position),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.item_value (item_value),
		.status     (status),
		.count      (count),
		.last       (last)
	);

	// count never passes capacity
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		sts.cnt <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// list is frozen while a dump streams
	a_dump_stable: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_dump |=> $stable(sts.cnt))
		else $error("count changed during dump");

	// no edit while a dump result is being loaded
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_dump && cmd.apply))
		else $error("transfer accepted during dump");

	// count changes only with an accepted transfer
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.apply |=> $stable(sts.cnt))
		else $error("count changed without a transfer");

endmodule

/* rtl/plid_ctrl.sv */
// ----------------------------------------------------------------------------
// plid_ctrl
// Handshake control and dump sequencer for the positional list.
// ----------------------------------------------------------------------------
module plid_ctrl import plid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] op,
	output logic       out_valid,
	input  logic       out_stall,
	input  plid_sts_t  sts,
	output plid_cmd_t  cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DUMP = 1'b1;

	logic             state_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic             out_free;
	logic             accept;
	logic             dump_go;
	logic             last_elem;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || !out_free;
	assign accept    = in_valid && !in_stall;
	assign dump_go   = accept && (op == OP_DUMP) && !sts.empty;
	assign last_elem = (CNT_W'(idx_q) + CNT_W'(1)) == sts.cnt;

	assign cmd.apply     = accept;
	assign cmd.emit_edit = accept && !dump_go;
	assign cmd.emit_dump = (state_q == S_DUMP) && out_free;
	assign cmd.dump_idx  = idx_q;
	assign cmd.dump_last = last_elem;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit_edit || cmd.emit_dump) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (dump_go) begin
						state_q <= S_DUMP;
						idx_q   <= '0;
					end
				end
				S_DUMP: begin
					if (cmd.emit_dump) begin
						idx_q <= idx_q + IDX_W'(1);
						if (last_elem) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/plid_dp.sv */
// ----------------------------------------------------------------------------
// plid_dp
// Shifting cell chain, entry count and result register.
// ----------------------------------------------------------------------------
module plid_dp import plid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         op,
	input  logic [7:0]         position,
	input  logic signed [31:0] value,
	input  plid_cmd_t          cmd,
	output plid_sts_t          sts,
	output logic signed [31:0] item_value,
	output logic [1:0]         status,
	output logic [6:0]         count,
	output logic               last
);

	logic signed [31:0] cell_q [CAPACITY];
	logic signed [31:0] cell_d [CAPACITY];
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_d;

	logic               full;
	logic               is_ins;
	logic               is_del;
	logic [8:0]         pos9;
	logic [8:0]         cnt9;
	logic [7:0]         slot;
	logic [1:0]         edit_st;
	logic               do_ins;
	logic               do_del;

	logic signed [31:0] item_q;
	logic [1:0]         status_q;
	logic [6:0]         count_q;
	logic               last_q;

	assign full   = cnt_q == CNT_W'(CAPACITY);
	assign is_ins = (op == OP_PREPEND) || (op == OP_APPEND) || (op == OP_INSERT);
	assign is_del = op == OP_DELETE;
	assign pos9   = {1'b0, position};
	assign cnt9   = 9'(cnt_q);

	always_comb begin
		slot    = 8'd0;
		edit_st = STAT_NOENT;
		case (op)
			OP_PREPEND: begin
				slot    = 8'd0;
				edit_st = full ? STAT_FULL : STAT_OK;
			end
			OP_APPEND: begin
				slot    = 8'(cnt_q);
				edit_st = full ? STAT_FULL : STAT_OK;
			end
			OP_INSERT: begin
				slot = position - 8'd1;
				if (full) begin
					edit_st = STAT_FULL;
				end else if (position == 8'd0 || pos9 > cnt9 + 9'd1) begin
					edit_st = STAT_NOENT;
				end else begin
					edit_st = STAT_OK;
				end
			end
			OP_DELETE: begin
				slot    = position - 8'd1;
				edit_st = (position == 8'd0 || pos9 > cnt9) ? STAT_NOENT : STAT_OK;
			end
			default: begin
				slot    = 8'd0;
				edit_st = STAT_NOENT;
			end
		endcase
	end

	assign do_ins = cmd.apply && is_ins && (edit_st == STAT_OK);
	assign do_del = cmd.apply && is_del && (edit_st == STAT_OK);

	// each cell picks its neighbor, the new value, or holds
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		always_comb begin
			cell_d[g] = cell_q[g];
			if (do_ins) begin
				if (8'(g) == slot) begin
					cell_d[g] = value;
				end else if (8'(g) > slot) begin
					if (g > 0) begin
						cell_d[g] = cell_q[(g > 0) ? g - 1 : 0];
					end
				end
			end else if (do_del) begin
				if (8'(g) >= slot) begin
					cell_d[g] = cell_q[(g < CAPACITY - 1) ? g + 1 : g];
				end
			end
		end
		always_ff @(posedge clk) begin
			cell_q[g] <= cell_d[g];
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (do_ins) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (do_del) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_edit) begin
			item_q   <= '0;
			status_q <= edit_st;
			count_q  <= 7'(cnt_d);
			last_q   <= 1'b1;
		end else if (cmd.emit_dump) begin
			item_q   <= cell_q[cmd.dump_idx];
			status_q <= STAT_OK;
			count_q  <= 7'(cnt_q);
			last_q   <= cmd.dump_last;
		end
	end

	assign sts.cnt   = cnt_q;
	assign sts.empty = cnt_q == '0;

	assign item_value = item_q;
	assign status     = status_q;
	assign count      = count_q;
	assign last       = last_q;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives list edits and dumps into positional_list_insert_delete. A
// scoreboard keeps its own copy of the list, predicts every result of each
// input transfer, and checks each output transfer field by field, in order.
// Both sides insert random wait cycles. The receiver also holds off once for
// a long stretch, which backs up the block.
// ----------------------------------------------------------------------------
module testbench;
	import plid_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] OP_LAST_CODE    = 3'd7;
	localparam int RANDOM_ITEMS = 124;
	localparam int HOLD_CYCLES  = 80;
	localparam int QUIET_LIMIT  = 1000;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		logic signed [31:0] item_value;
		logic [1:0]         status;
		logic [6:0]         count;
		logic               last;
	} list_reply_t;

	class list_scoreboard;
		logic signed [31:0] cells [CAPACITY];
		int                 held;
		list_reply_t        replies_due [$];
		int                 failures;

		function new();
			held = 0;
			failures = 0;
		endfunction

		function void push_reply(logic signed [31:0] v, logic [1:0] st, logic fin);
			list_reply_t r;
			r.item_value = v;
			r.status = st;
			r.count = 7'(held);
			r.last = fin;
			replies_due.push_back(r);
		endfunction

		function logic [1:0] insert_at(int pos1, logic signed [31:0] v);
			int i;
			if (held >= CAPACITY)
				return STAT_FULL;
			if (pos1 < 1 || pos1 > held + 1)
				return STAT_NOENT;
			for (i = held; i > pos1 - 1; i--)
				cells[i] = cells[i - 1];
			cells[pos1 - 1] = v;
			held++;
			return STAT_OK;
		endfunction

		function logic [1:0] delete_at(int pos1);
			int i;
			if (pos1 < 1 || pos1 > held)
				return STAT_NOENT;
			for (i = pos1 - 1; i + 1 < held; i++)
				cells[i] = cells[i + 1];
			held--;
			return STAT_OK;
		endfunction

		// note one accepted input transfer and queue the results it causes
		function void apply_op(logic [2:0] o, logic [7:0] p, logic signed [31:0] v);
			logic [1:0] st;
			int i;
			case (o)
				OP_PREPEND: st = insert_at(1, v);
				OP_APPEND:  st = insert_at(held + 1, v);
				OP_INSERT:  st = insert_at(p, v);
				OP_DELETE:  st = delete_at(p);
				OP_DUMP: begin
					if (held == 0) begin
						push_reply('0, STAT_NOENT, 1'b1);
					end else begin
						for (i = 0; i < held; i++)
							push_reply(cells[i], STAT_OK, i == held - 1);
					end
					return;
				end
				default: st = STAT_NOENT;
			endcase
			push_reply('0, st, 1'b1);
		endfunction

		function void check_result(logic signed [31:0] v, logic [1:0] st,
				logic [6:0] cnt, logic fin);
			list_reply_t r;
			if (replies_due.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("unexpected result: value %0d status %0d count %0d last %0b",
						v, st, cnt, fin);
				return;
			end
			r = replies_due.pop_front();
			if (v !== r.item_value || st !== r.status || cnt !== r.count ||
					fin !== r.last) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$write("mismatch: exp value %0d status %0d count %0d last %0b, ",
						r.item_value, r.status, r.count, r.last);
					$display("got value %0d status %0d count %0d last %0b",
						v, st, cnt, fin);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         op;
	logic [7:0]         position;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] item_value;
	logic [1:0]         status;
	logic [6:0]         count;
	logic               last;

	list_scoreboard sb = new();
	bit hold_req;
	int quiet_cycles;
	int send_left, recv_left;
	bit send_calm, recv_calm;

	positional_list_insert_delete u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.item_value (item_value),
		.status     (status),
		.count      (count),
		.last       (last)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// wait cycles come in runs: some runs have none at all
	function automatic int pick_wait(inout int left, inout bit calm);
		if (left == 0) begin
			left = $urandom_range(4, 24);
			calm = ($urandom_range(0, 3) == 0);
		end
		left--;
		return calm ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// present one item and hold it until the block takes it
	task automatic send_op(logic [2:0] o, logic [7:0] p, logic signed [31:0] v);
		int gap;
		gap = pick_wait(send_left, send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		position <= p;
		value <= v;
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
		end
		@(posedge clk);
		sb.apply_op(o, p, v);
	endtask

	// mode 0 grows the list, 1 shrinks it, 2 mixes
	task automatic send_random(int mode);
		int r, ins_pct, del_pct, dump_pct;
		logic [2:0] o;
		logic [7:0] p;
		ins_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 45;
		del_pct = (mode == 0) ? 85 : (mode == 1) ? 80 : 80;
		dump_pct = (mode == 0) ? 95 : (mode == 1) ? 92 : 94;
		r = $urandom_range(0, 99);
		p = 8'($urandom_range(0, 255));
		if (r < ins_pct) begin
			case ($urandom_range(0, 2))
				0: o = OP_PREPEND;
				1: o = OP_APPEND;
				default: o = OP_INSERT;
			endcase
			if (o == OP_INSERT && $urandom_range(0, 9) != 0)
				p = 8'($urandom_range(1, sb.held + 1));
		end else if (r < del_pct) begin
			o = OP_DELETE;
			if (sb.held > 0 && $urandom_range(0, 9) != 0)
				p = 8'($urandom_range(1, sb.held));
		end else if (r < dump_pct) begin
			o = OP_DUMP;
		end else begin
			o = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
		end
		send_op(o, p, pick_value());
	endtask

	// receiver: stall pattern
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = pick_wait(recv_left, recv_calm);
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				out_stall <= 1'b0;
			end
			forever begin
				@(negedge clk);
				if (out_valid)
					break;
			end
			@(posedge clk);
		end
	end

	// result monitor: sample mid-cycle, check once the transfer completes
	initial begin
		logic signed [31:0] v;
		logic [1:0] st;
		logic [6:0] cnt;
		logic fin;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (out_valid && !out_stall) begin
				v = item_value;
				st = status;
				cnt = count;
				fin = last;
				@(posedge clk);
				sb.check_result(v, st, cnt, fin);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("timeout: no transfer for %0d cycles", quiet_cycles);
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		int k, mode, seg;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_PREPEND;
		position = '0;
		value = '0;
		out_stall = 1'b0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corners
		send_op(OP_DUMP, 8'd0, '0);
		send_op(OP_DELETE, 8'd1, '0);
		send_op(OP_INSERT, 8'd0, 32'sd5);

		// fill to capacity through every insert form
		for (k = 0; k < CAPACITY; k++) begin
			case (k)
				0: send_op(OP_PREPEND, 8'd0, 32'sh8000_0000);
				1: send_op(OP_APPEND, 8'd255, 32'sh7fff_ffff);
				2: send_op(OP_INSERT, 8'd1, -32'sd1);
				3: send_op(OP_INSERT, 8'(sb.held + 1), '0);
				4: send_op(OP_INSERT, 8'd2, 32'sh5555_5555);
				5: send_op(OP_INSERT, 8'd3, 32'shaaaa_aaaa);
				default: begin
					case ($urandom_range(0, 2))
						0: send_op(OP_PREPEND, 8'($urandom_range(0, 255)), $urandom);
						1: send_op(OP_APPEND, 8'($urandom_range(0, 255)), $urandom);
						default: send_op(OP_INSERT,
							8'($urandom_range(1, sb.held + 1)), $urandom);
					endcase
				end
			endcase
		end

		// full is reported ahead of a bad position; then a dump, deletes and an unused code
		send_op(OP_APPEND, 8'd255, $urandom);
		send_op(OP_INSERT, 8'd0, $urandom);
		send_op(OP_DUMP, 8'd0, '0);
		send_op(OP_DELETE, 8'd0, '0);
		send_op(OP_DELETE, 8'(CAPACITY + 1), '0);
		send_op(OP_DELETE, 8'd8, '0);
		send_op(OP_LAST_CODE, 8'd255, -32'sd1);

		// random part; the receiver backs off for a long stretch at its start
		hold_req = 1'b1;
		k = 0;
		while (k < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 2);
			seg = $urandom_range(10, 40);
			while (seg > 0 && k < RANDOM_ITEMS) begin
				send_random(mode);
				seg--;
				k++;
			end
		end
		in_valid <= 1'b0;

		while (sb.replies_due.size() != 0)
			@(posedge clk);
		repeat (CAPACITY + 8) @(posedge clk);
		if (sb.failures == 0 && sb.replies_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

/* filelist.f */
rtl/plid_pkg.sv
rtl/plid_ctrl.sv
rtl/plid_dp.sv
rtl/positional_list_insert_delete.sv
tb/testbench.sv
